// ----- rtl/core/min_cyclic_hamming_distance_unit_assert.svh -----
// assertion macros for the cyclic hamming distance unit
// clock is clk, reset is rst_n (active low) in every user
`ifndef MIN_CYCLIC_HAMMING_DISTANCE_UNIT_ASSERT_SVH
`define MIN_CYCLIC_HAMMING_DISTANCE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising clock edge outside reset
`define MCHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define MCHD_ASSERT_NEVER(label, expr, msg) \
    `MCHD_ASSERT(label, !(expr), msg)

`else

`define MCHD_ASSERT(label, prop, msg)
`define MCHD_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- rtl/core/mchd_pkg.sv -----
package mchd_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int LETTER_W = 8;

    // input item modes
    localparam logic [1:0] MODE_TARGET = 2'd0;
    localparam logic [1:0] MODE_CAND   = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [LETTER_W-1:0] letter;
    } in_item_t;

    typedef struct packed {
        logic [7:0] distance;
        logic [5:0] rotation;
        logic       rotation_valid;
        logic       overflow;
    } out_item_t;

    // control travelling with one pair of memory reads
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              final_rot;
        logic [ADDR_W-1:0] rot;
    } scan_ctrl_t;

endpackage

// ----- rtl/core/mchd_ram.sv -----
module mchd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mchd_scorer.sv -----
module mchd_scorer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mchd_pkg::scan_ctrl_t           ctrl,
    input  logic [mchd_pkg::LETTER_W-1:0]  t_data,
    input  logic [mchd_pkg::LETTER_W-1:0]  c_data,
    input  logic [mchd_pkg::LEN_W-1:0]     diff,
    output logic [mchd_pkg::LEN_W-1:0]     best,
    output logic [mchd_pkg::ADDR_W-1:0]    best_rot,
    output logic                           done
);

    mchd_pkg::scan_ctrl_t              ctrl_reg;
    logic [mchd_pkg::LEN_W-1:0]        score_reg;
    logic [mchd_pkg::LEN_W-1:0]        score_next;
    logic [mchd_pkg::LEN_W-1:0]        best_reg;
    logic [mchd_pkg::ADDR_W-1:0]       best_rot_reg;
    logic                              done_reg;
    logic                              mism;

    // ctrl_reg lines up with the registered read data
    assign mism       = (t_data != c_data);
    assign score_next = (ctrl_reg.first ? diff : score_reg)
                        + mchd_pkg::LEN_W'(mism);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl;
            done_reg <= ctrl_reg.valid && ctrl_reg.last && ctrl_reg.final_rot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_reg.valid)
        begin
            score_reg <= score_next;
            // strict less keeps the first rotation on a tie
            if (ctrl_reg.last && ((ctrl_reg.rot == '0) || (score_next < best_reg)))
            begin
                best_reg     <= score_next;
                best_rot_reg <= ctrl_reg.rot;
            end
        end
    end

    assign best     = best_reg;
    assign best_rot = best_rot_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/core/min_cyclic_hamming_distance_unit.sv -----
// minimum cyclic hamming distance unit
//
// input channel (in_valid / in_stall / in_data) carries one transaction per
// item: mode target appends a letter to the target word, mode candidate
// appends to the candidate word, mode evaluate scores every rotation of the
// target against the candidate and then empties both words. mode 3 is ignored.
// letters past the store depth are dropped and flagged in overflow.
//
// load transactions are taken back to back while idle. an evaluate transaction scans both
// letter memories one compare per cycle: min(lengths) compares for each of
// the target_length rotations, set by the single read port of each memory;
// then the scorer drains and the result is registered. an empty word skips
// the scan. in_stall stays high for the whole scan.
//
// output channel (out_valid / out_stall / out_data) gives one transaction per
// evaluate. the result sits in an output register, so loads continue while the
// receiver stalls; only a finished evaluate waits for the register to empty.
// reset empties both words and clears the drop flag; memory contents are
// never cleared since only written entries are read.
`include "min_cyclic_hamming_distance_unit_assert.svh"

module min_cyclic_hamming_distance_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mchd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mchd_pkg::out_item_t out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [mchd_pkg::LEN_W-1:0]      tlen_reg, tlen_next;
    logic [mchd_pkg::LEN_W-1:0]      clen_reg, clen_next;
    logic                            drop_reg, drop_next;
    logic                            direct_reg, direct_next;
    logic [mchd_pkg::ADDR_W-1:0]     rot_reg, rot_next;
    logic [mchd_pkg::ADDR_W-1:0]     pos_reg, pos_next;
    logic [mchd_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    mchd_pkg::out_item_t             out_data_reg, out_data_next;

    logic                            in_acc;
    logic                            tfull, cfull;
    logic                            wr_t, wr_c;
    logic [mchd_pkg::LEN_W-1:0]      min_len;
    logic [mchd_pkg::LEN_W-1:0]      diff;
    logic                            last_pos;
    logic                            last_rot;
    logic                            idx_wrap;
    mchd_pkg::scan_ctrl_t            scan_ctrl;
    logic [mchd_pkg::LETTER_W-1:0]   t_rdata, c_rdata;
    logic [mchd_pkg::LEN_W-1:0]      sc_best;
    logic [mchd_pkg::ADDR_W-1:0]     sc_best_rot;
    logic                            sc_done;

    // only idle takes transactions, so loads never overlap a scan
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign tfull = (tlen_reg == mchd_pkg::LEN_W'(mchd_pkg::MAX_LEN));
    assign cfull = (clen_reg == mchd_pkg::LEN_W'(mchd_pkg::MAX_LEN));
    assign wr_t  = in_acc && (in_data.mode == mchd_pkg::MODE_TARGET) && !tfull;
    assign wr_c  = in_acc && (in_data.mode == mchd_pkg::MODE_CAND) && !cfull;

    assign min_len = (tlen_reg < clen_reg) ? tlen_reg : clen_reg;
    assign diff    = (tlen_reg > clen_reg) ? (tlen_reg - clen_reg)
                                           : (clen_reg - tlen_reg);

    // scan position: rotation rot_reg, candidate letter pos_reg,
    // target letter idx_reg = (rot + pos) mod target length
    assign last_pos = ((mchd_pkg::LEN_W'(pos_reg) + mchd_pkg::LEN_W'(1)) == min_len);
    assign last_rot = ((mchd_pkg::LEN_W'(rot_reg) + mchd_pkg::LEN_W'(1)) == tlen_reg);
    assign idx_wrap = ((mchd_pkg::LEN_W'(idx_reg) + mchd_pkg::LEN_W'(1)) == tlen_reg);

    always_comb
    begin
        scan_ctrl.valid     = (state_reg == ST_SCAN);
        scan_ctrl.first     = (pos_reg == '0);
        scan_ctrl.last      = last_pos;
        scan_ctrl.final_rot = last_pos && last_rot;
        scan_ctrl.rot       = rot_reg;
    end

    mchd_ram #(
        .WIDTH (mchd_pkg::LETTER_W),
        .DEPTH (mchd_pkg::MAX_LEN)
    ) u_target_ram (
        .clk   (clk),
        .we    (wr_t),
        .waddr (tlen_reg[mchd_pkg::ADDR_W-1:0]),
        .wdata (in_data.letter),
        .raddr (idx_reg),
        .rdata (t_rdata)
    );

    mchd_ram #(
        .WIDTH (mchd_pkg::LETTER_W),
        .DEPTH (mchd_pkg::MAX_LEN)
    ) u_cand_ram (
        .clk   (clk),
        .we    (wr_c),
        .waddr (clen_reg[mchd_pkg::ADDR_W-1:0]),
        .wdata (in_data.letter),
        .raddr (pos_reg),
        .rdata (c_rdata)
    );

    mchd_scorer u_scorer (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .t_data   (t_rdata),
        .c_data   (c_rdata),
        .diff     (diff),
        .best     (sc_best),
        .best_rot (sc_best_rot),
        .done     (sc_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        tlen_next      = tlen_reg;
        clen_next      = clen_reg;
        drop_next      = drop_reg;
        direct_next    = direct_reg;
        rot_next       = rot_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.mode)
                        mchd_pkg::MODE_TARGET:
                        begin
                            if (tfull)
                                drop_next = 1'b1;
                            else
                                tlen_next = tlen_reg + mchd_pkg::LEN_W'(1);
                        end
                        mchd_pkg::MODE_CAND:
                        begin
                            if (cfull)
                                drop_next = 1'b1;
                            else
                                clen_next = clen_reg + mchd_pkg::LEN_W'(1);
                        end
                        mchd_pkg::MODE_EVAL:
                        begin
                            rot_next = '0;
                            pos_next = '0;
                            idx_next = '0;
                            // an empty word needs no scan: every rotation scores diff
                            if (min_len == '0)
                            begin
                                direct_next = 1'b1;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                direct_next = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (last_pos)
                begin
                    pos_next = '0;
                    if (last_rot)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        rot_next = rot_reg + mchd_pkg::ADDR_W'(1);
                        idx_next = rot_reg + mchd_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    pos_next = pos_reg + mchd_pkg::ADDR_W'(1);
                    idx_next = idx_wrap ? '0 : (idx_reg + mchd_pkg::ADDR_W'(1));
                end
            end

            ST_DRAIN:
            begin
                if (sc_done)
                    state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // wait until the output register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    if (direct_reg)
                    begin
                        out_data_next.distance       = 8'(diff);
                        out_data_next.rotation       = '0;
                        out_data_next.rotation_valid = (tlen_reg != '0);
                    end
                    else
                    begin
                        out_data_next.distance       = 8'(sc_best);
                        out_data_next.rotation       = 6'(sc_best_rot);
                        out_data_next.rotation_valid = 1'b1;
                    end
                    out_data_next.overflow = drop_reg;
                    tlen_next  = '0;
                    clen_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tlen_reg      <= '0;
            clen_reg      <= '0;
            drop_reg      <= 1'b0;
            direct_reg    <= 1'b0;
            rot_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tlen_reg      <= tlen_next;
            clen_reg      <= clen_next;
            drop_reg      <= drop_next;
            direct_reg    <= direct_next;
            rot_reg       <= rot_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MCHD_ASSERT_NEVER(a_no_write_while_busy, (state_reg != ST_IDLE) && (wr_t || wr_c), "letter memory written during evaluation")
    `MCHD_ASSERT(a_len_bound, (tlen_reg <= mchd_pkg::LEN_W'(mchd_pkg::MAX_LEN)) && (clen_reg <= mchd_pkg::LEN_W'(mchd_pkg::MAX_LEN)), "word length beyond store depth")
    `MCHD_ASSERT(a_done_in_drain, sc_done |-> (state_reg == ST_DRAIN), "scorer finished outside drain")
    `MCHD_ASSERT(a_eval_blocks_input, (in_acc && (in_data.mode == mchd_pkg::MODE_EVAL)) |=> in_stall, "evaluate did not block further input")

endmodule

// ----- tb/sv/mchd_checker.sv -----
module mchd_checker
    import mchd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LETTER_W-1:0] target_word [MAX_LEN];
    logic [LETTER_W-1:0] cand_word [MAX_LEN];
    int unsigned         tgt_len;
    int unsigned         cand_len;
    logic                letters_dropped;
    out_item_t           scores_due [$];
    int                  mismatches;

    // best rotation of the stored target against the stored candidate
    function automatic out_item_t score_rotations();
        out_item_t   res;
        int unsigned min_len;
        int unsigned len_gap;
        int unsigned score;
        int unsigned best;
        int unsigned best_rot;
        res = '0;
        best_rot = 0;
        if (tgt_len == 0)
        begin
            res.distance = 8'(cand_len);
        end
        else
        begin
            min_len = (tgt_len < cand_len) ? tgt_len : cand_len;
            len_gap = (tgt_len > cand_len) ? tgt_len - cand_len : cand_len - tgt_len;
            best = len_gap + min_len + 1;
            for (int unsigned rot = 0; rot < tgt_len; rot++)
            begin
                score = len_gap;
                for (int unsigned j = 0; j < min_len; j++)
                begin
                    if (target_word[(rot + j) % tgt_len] != cand_word[j])
                        score++;
                end
                if (score < best)
                begin
                    best = score;
                    best_rot = rot;
                end
            end
            res.distance = 8'(best);
            res.rotation = 6'(best_rot);
            res.rotation_valid = 1'b1;
        end
        res.overflow = letters_dropped;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t due;
        if (!rst_n)
        begin
            tgt_len = 0;
            cand_len = 0;
            letters_dropped = 1'b0;
            scores_due.delete();
            mismatches = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                case (in_data.mode)
                    MODE_TARGET:
                    begin
                        if (tgt_len < MAX_LEN)
                        begin
                            target_word[tgt_len] = in_data.letter;
                            tgt_len++;
                        end
                        else
                            letters_dropped = 1'b1;
                    end
                    MODE_CAND:
                    begin
                        if (cand_len < MAX_LEN)
                        begin
                            cand_word[cand_len] = in_data.letter;
                            cand_len++;
                        end
                        else
                            letters_dropped = 1'b1;
                    end
                    MODE_EVAL:
                    begin
                        scores_due.push_back(score_rotations());
                        tgt_len = 0;
                        cand_len = 0;
                        letters_dropped = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (scores_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with none expected: distance %0d",
                                 $realtime, out_data.distance);
                end
                else
                begin
                    due = scores_due.pop_front();
                    if (out_data.distance !== due.distance
                        || out_data.rotation !== due.rotation
                        || out_data.rotation_valid !== due.rotation_valid
                        || out_data.overflow !== due.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected distance %0d rotation %0d ",
                                     $realtime, due.distance, due.rotation,
                                     "valid %0b overflow %0b, ",
                                     due.rotation_valid, due.overflow,
                                     "got distance %0d rotation %0d ",
                                     out_data.distance, out_data.rotation,
                                     "valid %0b overflow %0b",
                                     out_data.rotation_valid, out_data.overflow);
                    end
                end
            end
            errors <= mismatches;
            pending <= scores_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_min_cyclic_hamming_distance_unit.sv -----
module tb_min_cyclic_hamming_distance_unit;
    import mchd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD     = 20;
    localparam int         TIMEOUT_CYCLES = 1_000_000;
    localparam int         RANDOM_ITEMS   = 1400;
    localparam int         LONG_HOLD      = 600;
    localparam int         DRAIN_CYCLES   = 8;
    // mode with no meaning, the block must ignore it
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int check_errors;
    int results_pending;

    // counts of load and evaluate transactions sent (ignored mode excluded)
    int sent_count;
    // remaining transactions that the sender offers back to back
    int send_burst;

    min_cyclic_hamming_distance_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // watches both channels, predicts every evaluate and compares
    mchd_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (check_errors),
        .pending   (results_pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // one input transaction: random gap first, then hold until accepted
    // valid stays high across back-to-back transactions, it is only lowered for a gap
    task automatic send_item(input logic [1:0] mode, input logic [7:0] letter);
        int gap;
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 49) == 0)
                send_burst = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data.mode <= mode;
        in_data.letter <= letter;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (mode != MODE_UNUSED)
            sent_count++;
    endtask

    // stop offering and wait until every evaluate has produced its result
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // receiver: random stall before each result, calm stretches with none,
    // and one long hold-off so the output register fills and the input stalls
    initial
    begin : result_sink
        int stall_cycles;
        int taken;
        int calm_left;
        out_stall <= 1'b0;
        taken = 0;
        calm_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (calm_left > 0)
            begin
                calm_left--;
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles = $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(5, 15);
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            if (taken == 25)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] tgt_seq [80];
        logic [7:0] cand_seq [80];
        logic [7:0] alphabet [4];
        int         alpha_n;
        int         tl;
        int         cl;
        int         eff_tl;
        int         ti;
        int         ci;
        int         shift;
        int         seq_no;
        int         noise_n;
        int         random_goal;
        bit         full_range;
        bit         paused;

        in_valid <= 1'b0;
        in_data <= '0;
        rst_n <= 1'b0;
        sent_count = 0;
        send_burst = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both words empty: distance 0, no valid rotation
        send_item(MODE_EVAL, 8'h00);
        // empty target: distance is the candidate length, rotation invalid
        send_item(MODE_CAND, 8'h7f);
        send_item(MODE_CAND, 8'h80);
        send_item(MODE_EVAL, 8'hff);
        // empty candidate: every rotation scores the target length
        send_item(MODE_TARGET, 8'h80);
        send_item(MODE_TARGET, 8'h7f);
        send_item(MODE_TARGET, 8'h00);
        send_item(MODE_EVAL, 8'h00);
        // exact match at rotation 2, with an ignored transaction in between
        send_item(MODE_TARGET, 8'h01);
        send_item(MODE_TARGET, 8'h80);
        send_item(MODE_TARGET, 8'h7f);
        send_item(MODE_UNUSED, 8'h55);
        send_item(MODE_CAND, 8'h7f);
        send_item(MODE_CAND, 8'h01);
        send_item(MODE_CAND, 8'h80);
        send_item(MODE_EVAL, 8'haa);
        // longer target, single candidate letter, match at the last rotation
        send_item(MODE_TARGET, 8'hff);
        send_item(MODE_TARGET, 8'hff);
        send_item(MODE_TARGET, 8'h05);
        send_item(MODE_CAND, 8'h05);
        send_item(MODE_EVAL, 8'h00);
        // tie between rotations: the first one must win
        send_item(MODE_TARGET, 8'h07);
        send_item(MODE_TARGET, 8'h07);
        send_item(MODE_CAND, 8'h07);
        send_item(MODE_EVAL, 8'h00);

        // random part: mostly well-formed load-load-evaluate sequences
        random_goal = sent_count + RANDOM_ITEMS;
        seq_no = 0;
        paused = 1'b0;
        while (sent_count < random_goal)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // noise and broken sequences: any mode, any letter
                noise_n = $urandom_range(1, 6);
                repeat (noise_n) send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
            else
            begin
                // every twentieth sequence is large and may run past the store depth
                if (seq_no % 20 == 5)
                begin
                    tl = (seq_no == 5) ? 70 : $urandom_range(56, 70);
                    cl = $urandom_range(50, 70);
                end
                else
                begin
                    tl = $urandom_range(0, 8);
                    cl = $urandom_range(0, 8);
                end
                eff_tl = (tl > MAX_LEN) ? MAX_LEN : tl;
                // small alphabets make matches and ties likely
                full_range = ($urandom_range(0, 3) == 0);
                alpha_n = $urandom_range(1, 4);
                foreach (alphabet[k])
                    alphabet[k] = 8'($urandom);
                for (int k = 0; k < tl; k++)
                    tgt_seq[k] = full_range ? 8'($urandom) : alphabet[$urandom_range(0, alpha_n - 1)];
                // candidate mostly follows a rotation of the target
                shift = (eff_tl > 0) ? $urandom_range(0, eff_tl - 1) : 0;
                for (int k = 0; k < cl; k++)
                begin
                    if (eff_tl > 0 && $urandom_range(0, 3) != 0)
                        cand_seq[k] = tgt_seq[(shift + k) % eff_tl];
                    else
                        cand_seq[k] = full_range ? 8'($urandom)
                                                 : alphabet[$urandom_range(0, alpha_n - 1)];
                end
                // interleave the two words at random
                ti = 0;
                ci = 0;
                while (ti < tl || ci < cl)
                begin
                    if (ci >= cl || (ti < tl && $urandom_range(0, 1) == 1))
                    begin
                        send_item(MODE_TARGET, tgt_seq[ti]);
                        ti++;
                    end
                    else
                    begin
                        send_item(MODE_CAND, cand_seq[ci]);
                        ci++;
                    end
                end
                send_item(MODE_EVAL, 8'($urandom));
                seq_no++;
            end
            // once midway, let the block empty completely before going on
            if (!paused && sent_count >= random_goal - RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
